/* design/bsd_pkg.sv */
// Shared types, constants and helper functions of the stencil derivative block.
// Depends on nothing; every other design file except bsd_if imports it.
`default_nettype none

package bsd_pkg;

    localparam int TAPS           = 9;
    localparam int WEIGHT_BITS    = 8;
    localparam int CFG_DATA_BITS  = 32;
    localparam int CFG_INDEX_BITS = 1;
    localparam int INV_BITS       = 32;
    localparam int LO_BITS        = 32;
    localparam int FRAC_BITS      = 16;

    localparam logic [INV_BITS-1:0] INV_RESET  = 32'd65536;
    localparam logic [3:0]          ROOM_SIDED  = 4'd4;
    localparam logic [3:0]          ROOM_ALMOST = 4'd3;
    localparam logic [3:0]          ROOM_BIASED = 4'd3;
    localparam logic [3:0]          ROOM_CENTRAL = 4'd1;

    typedef enum logic [1:0] {
        CMD_FIRST     = 2'd0,
        CMD_SECOND    = 2'd1,
        CMD_FIRST_FWD = 2'd2,
        CMD_FIRST_BWD = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_CENTRAL      = 3'd0,
        ST_RIGHT        = 3'd1,
        ST_LEFT         = 3'd2,
        ST_ALMOST_RIGHT = 3'd3,
        ST_ALMOST_LEFT  = 3'd4,
        ST_NONE         = 3'd5
    } stencil_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_INV_H    = 1'b0,
        REG_INV_H_SQ = 1'b1
    } cfg_reg_t;

    typedef logic signed [WEIGHT_BITS-1:0] weight_t;

    typedef struct packed {
        stencil_t stencil;
        logic     second;
    } ctl_t;

    // Integer weights over 12h, tap 0 is four steps back. Rows past ST_NONE are zero.
    localparam weight_t FIRST_W [8][TAPS] = '{
        '{  0,   0,   1,  -8,   0,   8,  -1,   0,   0 },
        '{  0,   0,   0,   0, -22,  36, -18,   4,   0 },
        '{  0,  -4,  18, -36,  22,   0,   0,   0,   0 },
        '{  0,   0,   0,  -3, -10,  18,  -6,   1,   0 },
        '{  0,  -1,   6, -18,  10,   3,   0,   0,   0 },
        '{  0,   0,   0,   0,   0,   0,   0,   0,   0 },
        '{  0,   0,   0,   0,   0,   0,   0,   0,   0 },
        '{  0,   0,   0,   0,   0,   0,   0,   0,   0 }
    };

    // Integer weights over 12h squared.
    localparam weight_t SECOND_W [8][TAPS] = '{
        '{  0,   0,  -1,  16, -30,  16,  -1,   0,   0 },
        '{  0,   0,   0,   0,  35,-104, 114, -56,  11 },
        '{ 11, -56, 114,-104,  35,   0,   0,   0,   0 },
        '{  0,   0,   0,  10, -15,  -4,  14,  -6,   1 },
        '{  1,  -6,  14,  -4, -15,  10,   0,   0,   0 },
        '{  0,   0,   0,   0,   0,   0,   0,   0,   0 },
        '{  0,   0,   0,   0,   0,   0,   0,   0,   0 },
        '{  0,   0,   0,   0,   0,   0,   0,   0,   0 }
    };

    function automatic weight_t weight_of(logic second, stencil_t st, logic [3:0] tap);
        return second ? SECOND_W[st][tap] : FIRST_W[st][tap];
    endfunction

    // Width of one weighted tap.
    function automatic int term_bits(int sample_bits);
        return sample_bits + WEIGHT_BITS;
    endfunction

    // Width of the signed tap sum; the weight magnitudes of a row add up to below 512.
    function automatic int sum_bits(int sample_bits);
        return sample_bits + 10;
    endfunction

    // Width of the magnitude, at least one bit above the low multiplier half.
    function automatic int mag_bits(int sample_bits);
        return (sum_bits(sample_bits) > LO_BITS) ? sum_bits(sample_bits) : LO_BITS + 1;
    endfunction

    function automatic int prod_bits(int sample_bits);
        return mag_bits(sample_bits) + INV_BITS;
    endfunction

    function automatic int quot_bits(int sample_bits);
        return prod_bits(sample_bits) - FRAC_BITS;
    endfunction

endpackage

`default_nettype wire

/* design/bsd_if.sv */
// Valid/ready channel interfaces for the window input and the result output.
// Depends on nothing; widths follow the SAMPLE_BITS parameter.
`default_nettype none

interface bsd_in_if #(parameter int SAMPLE_BITS = 32);
    logic                          valid;
    logic                          ready;
    logic [1:0]                    cmd;
    logic signed [SAMPLE_BITS-1:0] sample_back4;
    logic signed [SAMPLE_BITS-1:0] sample_back3;
    logic signed [SAMPLE_BITS-1:0] sample_back2;
    logic signed [SAMPLE_BITS-1:0] sample_back1;
    logic signed [SAMPLE_BITS-1:0] sample_center;
    logic signed [SAMPLE_BITS-1:0] sample_ahead1;
    logic signed [SAMPLE_BITS-1:0] sample_ahead2;
    logic signed [SAMPLE_BITS-1:0] sample_ahead3;
    logic signed [SAMPLE_BITS-1:0] sample_ahead4;
    logic [3:0]                    left_room;
    logic [3:0]                    right_room;

    modport source (
        output valid, cmd, sample_back4, sample_back3, sample_back2, sample_back1,
               sample_center, sample_ahead1, sample_ahead2, sample_ahead3, sample_ahead4,
               left_room, right_room,
        input  ready
    );

    modport sink (
        input  valid, cmd, sample_back4, sample_back3, sample_back2, sample_back1,
               sample_center, sample_ahead1, sample_ahead2, sample_ahead3, sample_ahead4,
               left_room, right_room,
        output ready
    );
endinterface

interface bsd_out_if #(parameter int SAMPLE_BITS = 32);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] derivative;
    logic [2:0]                    stencil_used;
    logic                          saturated;

    modport source (output valid, derivative, stencil_used, saturated, input ready);
    modport sink (input valid, derivative, stencil_used, saturated, output ready);
endinterface

`default_nettype wire

/* design/boundary_aware_stencil_derivative.sv */
// Top level of the boundary aware stencil derivative: config registers, handshake, pipeline.
// Depends on bsd_pkg, bsd_if, bsd_select, bsd_sum, bsd_scale and bsd_clip.
`default_nettype none

// This block computes a fourth-order finite-difference derivative of one grid point
// per transaction. The window channel carries nine Q16.16 samples centered on the
// point, the free room on each side and a command (first derivative, second
// derivative, or first derivative biased forward or backward); the result channel
// returns the saturated derivative, the stencil that was used and a clip flag.
// The work runs in a six-stage pipeline: stencil choice and weighted taps, tap sum,
// sign and magnitude, two partial products against the reciprocal, rounding add, and
// saturation into the output register. A new transaction is accepted every cycle
// while the output register is free or being emptied. The edge that accepts a
// window loads the first stage, and the result then passes through each stage
// register in turn up to the output register. All stages move
// together: when a result sits in the output register and the sink does not take it,
// the whole pipeline holds and window.ready drops in the same cycle, so the sustained
// rate is one transaction per cycle set by the output handshake alone. The two
// reciprocal registers (1/(12h) and 1/(12h squared), Q16.16, reset to 1.0) are
// written through cfg_write, cfg_index and cfg_data and should only change while no
// transaction is in flight.
module boundary_aware_stencil_derivative #(
    parameter int SAMPLE_BITS = 32
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    bsd_in_if.sink                                   window,
    bsd_out_if.source                                result,
    input  wire logic                                cfg_write,
    input  wire logic [bsd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [bsd_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import bsd_pkg::*;

    localparam int TERM_BITS = term_bits(SAMPLE_BITS);
    localparam int MAG_BITS  = mag_bits(SAMPLE_BITS);
    localparam int QUOT_BITS = quot_bits(SAMPLE_BITS);

    logic [INV_BITS-1:0] inv_h_reg;
    logic [INV_BITS-1:0] inv_h_sq_reg;

    // One shared advance: the pipeline moves whenever the output register is free or
    // is being emptied in this cycle.
    logic advance;

    logic signed [SAMPLE_BITS-1:0] samples [TAPS];

    logic                        sel_valid;
    ctl_t                        sel_ctl;
    logic signed [TERM_BITS-1:0] sel_term [TAPS];

    logic                sum_valid;
    ctl_t                sum_ctl;
    logic                sum_neg;
    logic [MAG_BITS-1:0] sum_mag;

    logic                 scl_valid;
    ctl_t                 scl_ctl;
    logic                 scl_neg;
    logic [QUOT_BITS-1:0] scl_quot;

    assign advance      = !result.valid || result.ready;
    assign window.ready = advance;

    // Window fields in tap order, four steps back first.
    assign samples[0] = window.sample_back4;
    assign samples[1] = window.sample_back3;
    assign samples[2] = window.sample_back2;
    assign samples[3] = window.sample_back1;
    assign samples[4] = window.sample_center;
    assign samples[5] = window.sample_ahead1;
    assign samples[6] = window.sample_ahead2;
    assign samples[7] = window.sample_ahead3;
    assign samples[8] = window.sample_ahead4;

    // Configuration writes land directly in the reciprocal registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_h_reg    <= INV_RESET;
            inv_h_sq_reg <= INV_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_INV_H:    inv_h_reg    <= cfg_data[INV_BITS-1:0];
                REG_INV_H_SQ: inv_h_sq_reg <= cfg_data[INV_BITS-1:0];
            endcase
        end
    end

    bsd_select #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_select (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (advance),
        .in_valid   (window.valid),
        .cmd        (window.cmd),
        .samples    (samples),
        .left_room  (window.left_room),
        .right_room (window.right_room),
        .valid_reg  (sel_valid),
        .ctl_reg    (sel_ctl),
        .term_reg   (sel_term)
    );

    bsd_sum #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_sum (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .in_valid  (sel_valid),
        .in_ctl    (sel_ctl),
        .term      (sel_term),
        .valid_reg (sum_valid),
        .ctl_reg   (sum_ctl),
        .neg_reg   (sum_neg),
        .mag_reg   (sum_mag)
    );

    bsd_scale #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .in_valid  (sum_valid),
        .in_ctl    (sum_ctl),
        .in_neg    (sum_neg),
        .mag       (sum_mag),
        .inv_h     (inv_h_reg),
        .inv_h_sq  (inv_h_sq_reg),
        .valid_reg (scl_valid),
        .ctl_reg   (scl_ctl),
        .neg_reg   (scl_neg),
        .quot_reg  (scl_quot)
    );

    bsd_clip #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_clip (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (advance),
        .in_valid       (scl_valid),
        .in_ctl         (scl_ctl),
        .in_neg         (scl_neg),
        .quot           (scl_quot),
        .valid_reg      (result.valid),
        .derivative_reg (result.derivative),
        .stencil_reg    (result.stencil_used),
        .saturated_reg  (result.saturated)
    );

endmodule

`default_nettype wire

/* design/bsd_select.sv */
// First pipeline stage: stencil choice from command and room, and the nine weighted taps.
// Depends on bsd_pkg for the weight tables and the command and stencil codes.
`default_nettype none

module bsd_select #(
    parameter int SAMPLE_BITS = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic [1:0]                    cmd,
    input  wire logic signed [SAMPLE_BITS-1:0] samples [bsd_pkg::TAPS],
    input  wire logic [3:0]                    left_room,
    input  wire logic [3:0]                    right_room,
    output logic                               valid_reg,
    output bsd_pkg::ctl_t                      ctl_reg,
    output logic signed [bsd_pkg::term_bits(SAMPLE_BITS)-1:0] term_reg [bsd_pkg::TAPS]
);
    import bsd_pkg::*;

    localparam int TERM_BITS = term_bits(SAMPLE_BITS);

    cmd_t                  cmd_code;
    logic [3:0]            min_room;
    ctl_t                  ctl_next;
    weight_t               w [TAPS];
    logic signed [TERM_BITS-1:0] term_next [TAPS];

    assign cmd_code = cmd_t'(cmd);
    assign min_room = (left_room < right_room) ? left_room : right_room;

    // Biased commands override only when both sides have room to spare.
    always_comb
    begin
        ctl_next.second = (cmd_code == CMD_SECOND);
        if (cmd_code == CMD_FIRST_FWD && min_room > ROOM_BIASED)
        begin
            ctl_next.stencil = ST_ALMOST_RIGHT;
        end
        else if (cmd_code == CMD_FIRST_BWD && min_room > ROOM_BIASED)
        begin
            ctl_next.stencil = ST_ALMOST_LEFT;
        end
        else if (min_room > ROOM_CENTRAL)
        begin
            ctl_next.stencil = ST_CENTRAL;
        end
        else if (left_room == 4'd0 && right_room >= ROOM_SIDED)
        begin
            ctl_next.stencil = ST_RIGHT;
        end
        else if (left_room >= ROOM_SIDED && right_room == 4'd0)
        begin
            ctl_next.stencil = ST_LEFT;
        end
        else if (left_room == 4'd1 && right_room >= ROOM_ALMOST)
        begin
            ctl_next.stencil = ST_ALMOST_RIGHT;
        end
        else if (left_room >= ROOM_ALMOST && right_room == 4'd1)
        begin
            ctl_next.stencil = ST_ALMOST_LEFT;
        end
        else
        begin
            ctl_next.stencil = ST_NONE;
        end
    end

    // The empty stencil has all-zero weights, so its sum and result come out zero.
    always_comb
    begin
        for (int t = 0; t < TAPS; t++)
        begin
            w[t]         = weight_of(ctl_next.second, ctl_next.stencil, 4'(t));
            term_next[t] = TERM_BITS'(samples[t]) * TERM_BITS'(w[t]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctl_reg  <= ctl_next;
            term_reg <= term_next;
        end
    end

endmodule

`default_nettype wire

/* design/bsd_sum.sv */
// Second and third pipeline stages: the tap sum, then its sign and magnitude.
// Depends on bsd_pkg for widths and the control struct.
`default_nettype none

module bsd_sum #(
    parameter int SAMPLE_BITS = 32
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire bsd_pkg::ctl_t in_ctl,
    input  wire logic signed [bsd_pkg::term_bits(SAMPLE_BITS)-1:0] term [bsd_pkg::TAPS],
    output logic               valid_reg,
    output bsd_pkg::ctl_t      ctl_reg,
    output logic               neg_reg,
    output logic [bsd_pkg::mag_bits(SAMPLE_BITS)-1:0] mag_reg
);
    import bsd_pkg::*;

    localparam int SUM_BITS = sum_bits(SAMPLE_BITS);
    localparam int MAG_BITS = mag_bits(SAMPLE_BITS);

    logic signed [SUM_BITS-1:0] sum_next;
    logic signed [SUM_BITS-1:0] sum_reg;
    logic signed [SUM_BITS-1:0] abs_sum;
    logic                       sum_valid_reg;
    ctl_t                       sum_ctl_reg;

    always_comb
    begin
        sum_next = '0;
        for (int t = 0; t < TAPS; t++)
        begin
            sum_next = sum_next + SUM_BITS'(term[t]);
        end
    end

    // The sum never reaches the most negative code, so negation is exact.
    assign abs_sum = sum_reg[SUM_BITS-1] ? -sum_reg : sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_valid_reg <= 1'b0;
            valid_reg     <= 1'b0;
        end
        else if (en)
        begin
            sum_valid_reg <= in_valid;
            valid_reg     <= sum_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg     <= sum_next;
            sum_ctl_reg <= in_ctl;
            ctl_reg     <= sum_ctl_reg;
            neg_reg     <= sum_reg[SUM_BITS-1];
            mag_reg     <= MAG_BITS'($unsigned(abs_sum));
        end
    end

endmodule

`default_nettype wire

/* design/bsd_scale.sv */
// Fourth and fifth pipeline stages: magnitude times the reciprocal as two partial
// products, then their sum with the rounding half. Depends on bsd_pkg for widths.
`default_nettype none

module bsd_scale #(
    parameter int SAMPLE_BITS = 32
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            en,
    input  wire logic                            in_valid,
    input  wire bsd_pkg::ctl_t                   in_ctl,
    input  wire logic                            in_neg,
    input  wire logic [bsd_pkg::mag_bits(SAMPLE_BITS)-1:0] mag,
    input  wire logic [bsd_pkg::INV_BITS-1:0]    inv_h,
    input  wire logic [bsd_pkg::INV_BITS-1:0]    inv_h_sq,
    output logic                                 valid_reg,
    output bsd_pkg::ctl_t                        ctl_reg,
    output logic                                 neg_reg,
    output logic [bsd_pkg::quot_bits(SAMPLE_BITS)-1:0] quot_reg
);
    import bsd_pkg::*;

    localparam int MAG_BITS  = mag_bits(SAMPLE_BITS);
    localparam int HI_BITS   = MAG_BITS - LO_BITS;
    localparam int PROD_BITS = prod_bits(SAMPLE_BITS);
    localparam int LOP_BITS  = LO_BITS + INV_BITS;
    localparam int HIP_BITS  = HI_BITS + INV_BITS;

    logic [INV_BITS-1:0]  inv;
    logic [LOP_BITS-1:0]  lo_prod_reg;
    logic [HIP_BITS-1:0]  hi_prod_reg;
    logic                 prod_valid_reg;
    ctl_t                 prod_ctl_reg;
    logic                 prod_neg_reg;
    logic [PROD_BITS-1:0] total;

    assign inv = in_ctl.second ? inv_h_sq : inv_h;

    // Adding one half before dropping the fraction rounds the magnitude half away from zero.
    assign total = (PROD_BITS'(hi_prod_reg) << LO_BITS) + PROD_BITS'(lo_prod_reg)
                 + (PROD_BITS'(1) << (FRAC_BITS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            valid_reg      <= 1'b0;
        end
        else if (en)
        begin
            prod_valid_reg <= in_valid;
            valid_reg      <= prod_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lo_prod_reg  <= LOP_BITS'(mag[LO_BITS-1:0]) * LOP_BITS'(inv);
            hi_prod_reg  <= HIP_BITS'(mag[MAG_BITS-1:LO_BITS]) * HIP_BITS'(inv);
            prod_ctl_reg <= in_ctl;
            prod_neg_reg <= in_neg;
            ctl_reg      <= prod_ctl_reg;
            neg_reg      <= prod_neg_reg;
            quot_reg     <= total[PROD_BITS-1:FRAC_BITS];
        end
    end

endmodule

`default_nettype wire

/* design/bsd_clip.sv */
// Last pipeline stage: saturation to the sample range, sign restore and the output register.
// Depends on bsd_pkg for widths and the control struct.
`default_nettype none

module bsd_clip #(
    parameter int SAMPLE_BITS = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire logic                  in_valid,
    input  wire bsd_pkg::ctl_t         in_ctl,
    input  wire logic                  in_neg,
    input  wire logic [bsd_pkg::quot_bits(SAMPLE_BITS)-1:0] quot,
    output logic                       valid_reg,
    output logic signed [SAMPLE_BITS-1:0] derivative_reg,
    output logic [2:0]                 stencil_reg,
    output logic                       saturated_reg
);
    import bsd_pkg::*;

    localparam int QUOT_BITS = quot_bits(SAMPLE_BITS);
    localparam int TOP_BITS  = QUOT_BITS - SAMPLE_BITS + 1;

    localparam logic [SAMPLE_BITS-1:0] MAX_VAL = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] MIN_VAL = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic [TOP_BITS-1:0]    quot_top;
    logic                   over;
    logic                   at_min;
    logic                   sat;
    logic [SAMPLE_BITS-1:0] low;
    logic [SAMPLE_BITS-1:0] value;

    assign quot_top = quot[QUOT_BITS-1:SAMPLE_BITS-1];
    assign low      = quot[SAMPLE_BITS-1:0];
    assign over     = |quot_top;
    // A negative result may reach exactly the most negative code without clipping.
    assign at_min   = (quot_top == TOP_BITS'(1)) && (quot[SAMPLE_BITS-2:0] == '0);
    assign sat      = over && !(in_neg && at_min);

    always_comb
    begin
        if (sat)
        begin
            value = in_neg ? MIN_VAL : MAX_VAL;
        end
        else
        begin
            value = in_neg ? -low : low;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            derivative_reg <= $signed(value);
            stencil_reg    <= in_ctl.stencil;
            saturated_reg  <= sat;
        end
    end

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the boundary aware stencil derivative block.
// Depends on bsd_pkg, the bsd_in_if/bsd_out_if channels and the block's RTL.

module testbench;
    import bsd_pkg::*;

    // Tap 0 is four steps back, tap 8 four steps ahead, as on the window channel.
    typedef logic [8:0][31:0] window_taps_t;

    typedef struct packed {
        cmd_t         cmd;
        window_taps_t taps;
        logic [3:0]   left_room;
        logic [3:0]   right_room;
    } window_t;

    typedef struct packed {
        logic signed [31:0] derivative;
        stencil_t           stencil;
        logic               saturated;
    } derivative_t;

    // Integer stencil weights over 12h, one row per stencil except ST_NONE, in the order of stencil_t.
    // The left-hand rows are the right-hand ones mirrored and negated.
    localparam int SLOPE_WEIGHTS [5][9] = '{
        '{  0,   0,   1,  -8,   0,   8,  -1,   0,   0 },
        '{  0,   0,   0,   0, -22,  36, -18,   4,   0 },
        '{  0,  -4,  18, -36,  22,   0,   0,   0,   0 },
        '{  0,   0,   0,  -3, -10,  18,  -6,   1,   0 },
        '{  0,  -1,   6, -18,  10,   3,   0,   0,   0 }
    };

    // Integer stencil weights over 12h squared; left-hand rows are plain mirrors.
    localparam int CURVE_WEIGHTS [5][9] = '{
        '{  0,   0,  -1,  16, -30,  16,  -1,   0,   0 },
        '{  0,   0,   0,   0,  35,-104, 114, -56,  11 },
        '{ 11, -56, 114,-104,  35,   0,   0,   0,   0 },
        '{  0,   0,   0,  10, -15,  -4,  14,  -6,   1 },
        '{  1,  -6,  14,  -4, -15,  10,   0,   0,   0 }
    };

    // Idle percentages of the four traffic phases: none, sender only, receiver only, both.
    localparam int SEND_IDLE [4] = '{0, 75, 0, 17};
    localparam int RECV_STALL [4] = '{0, 0, 75, 17};

    localparam int SEGMENT_ITEMS = 165;
    localparam int ONE = 32'h0001_0000;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_write;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    bsd_in_if #(.SAMPLE_BITS(32)) window_ch ();
    bsd_out_if #(.SAMPLE_BITS(32)) result_ch ();

    boundary_aware_stencil_derivative #(.SAMPLE_BITS(32)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .window    (window_ch),
        .result    (result_ch),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Local copy of the two reciprocal registers, updated as they are written.
    logic [31:0] recip_h;
    logic [31:0] recip_h_sq;

    // Derivatives predicted for accepted windows, oldest first.
    derivative_t pending_derivatives [$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_off_left = 0;
    int error_count = 0;
    int results_checked = 0;
    int saturations_seen = 0;
    int configs_written = 0;
    int stencil_hits [6] = '{0, 0, 0, 0, 0, 0};

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Generous watchdog. The slowest correct run is roughly 1400 transactions, each
    // waiting out a few sender gaps and receiver stalls at 75 percent, plus the long
    // hold-off and the pipeline latency, all well within this limit.
    initial
    begin
        #5_000_000;
        $display("boundary_aware_stencil_derivative verification failed");
        $finish;
    end

    // Works out the expected result of one window under the current register values.
    // The room rules pick the stencil, the weighted sum is scaled by the matching
    // reciprocal with round-half-away-from-zero on the 16 dropped bits, and the
    // magnitude is clipped to the signed 32-bit range.
    function automatic derivative_t predict_derivative(window_t w);
        derivative_t outcome;
        logic [3:0] narrow;
        logic curve;
        stencil_t st;
        longint acc;
        logic [63:0] mag;
        logic [31:0] recip;
        logic [95:0] scaled;
        logic [79:0] quotient;
        logic [79:0] limit;
        curve = (w.cmd == CMD_SECOND);
        narrow = (w.left_room < w.right_room) ? w.left_room : w.right_room;
        if (w.cmd == CMD_FIRST_FWD && narrow > 3)
            st = ST_ALMOST_RIGHT;
        else if (w.cmd == CMD_FIRST_BWD && narrow > 3)
            st = ST_ALMOST_LEFT;
        else if (narrow > 1)
            st = ST_CENTRAL;
        else if (w.left_room == 0 && w.right_room >= 4)
            st = ST_RIGHT;
        else if (w.left_room >= 4 && w.right_room == 0)
            st = ST_LEFT;
        else if (w.left_room == 1 && w.right_room >= 3)
            st = ST_ALMOST_RIGHT;
        else if (w.left_room >= 3 && w.right_room == 1)
            st = ST_ALMOST_LEFT;
        else
            st = ST_NONE;
        outcome.derivative = '0;
        outcome.stencil = st;
        outcome.saturated = 1'b0;
        if (st != ST_NONE)
        begin
            acc = 0;
            for (int i = 0; i < 9; i++)
            begin
                acc += longint'(curve ? CURVE_WEIGHTS[int'(st)][i] : SLOPE_WEIGHTS[int'(st)][i])
                       * longint'($signed(w.taps[i]));
            end
            recip = curve ? recip_h_sq : recip_h;
            mag = (acc < 0) ? 64'(-acc) : 64'(acc);
            scaled = {32'd0, mag} * {64'd0, recip} + 96'h8000;
            quotient = scaled[95:16];
            limit = (acc < 0) ? 80'h8000_0000 : 80'h7FFF_FFFF;
            if (quotient > limit)
            begin
                quotient = limit;
                outcome.saturated = 1'b1;
            end
            outcome.derivative = (acc < 0) ? -quotient[31:0] : quotient[31:0];
        end
        return outcome;
    endfunction

    // Samples of a polynomial in the tap offset, coefficients in Q16.16.
    function automatic window_taps_t poly_taps(int slope, int curve);
        window_taps_t taps;
        for (int i = 0; i < 9; i++)
            taps[i] = 32'(slope * (i - 4) + curve * (i - 4) * (i - 4));
        return taps;
    endfunction

    function automatic int signed_span(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // Random window. Rooms lean toward the small values where the stencil choice
    // changes; samples come in one of several magnitude classes per window so that
    // unsaturated results stay common even with large reciprocals.
    function automatic window_t random_window();
        window_t w;
        int mode;
        w.cmd = cmd_t'($urandom_range(3));
        w.left_room = ($urandom_range(9) < 6) ? 4'($urandom_range(5)) : 4'($urandom_range(15));
        w.right_room = ($urandom_range(9) < 6) ? 4'($urandom_range(5)) : 4'($urandom_range(15));
        mode = $urandom_range(9);
        if (mode == 9)
            w.taps = poly_taps(signed_span(32'h0002_0000), signed_span(32'h0000_8000));
        for (int i = 0; i < 9; i++)
        begin
            case (mode)
                0, 1, 2, 3: w.taps[i] = 32'(signed_span(32'h0008_0000));
                4, 5:       w.taps[i] = 32'(signed_span(256));
                6, 7:       w.taps[i] = $urandom;
                8:
                begin
                    case ($urandom_range(4))
                        0: w.taps[i] = 32'h8000_0000;
                        1: w.taps[i] = 32'h7FFF_FFFF;
                        2: w.taps[i] = 32'h0000_0000;
                        3: w.taps[i] = 32'hFFFF_FFFF;
                        default: w.taps[i] = 32'h0000_0001;
                    endcase
                end
                default: w.taps[i] = w.taps[i] + 32'(signed_span(16));
            endcase
        end
        return w;
    endfunction

    // Offers one window and returns at the falling edge after it was accepted.
    // Valid is left high so that back-to-back windows never toggle it; it only
    // drops during a random gap or when the sender stops.
    task automatic send_window(input window_t w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            window_ch.valid <= 1'b0;
            @(negedge clk);
        end
        window_ch.valid <= 1'b1;
        window_ch.cmd <= w.cmd;
        window_ch.sample_back4 <= w.taps[0];
        window_ch.sample_back3 <= w.taps[1];
        window_ch.sample_back2 <= w.taps[2];
        window_ch.sample_back1 <= w.taps[3];
        window_ch.sample_center <= w.taps[4];
        window_ch.sample_ahead1 <= w.taps[5];
        window_ch.sample_ahead2 <= w.taps[6];
        window_ch.sample_ahead3 <= w.taps[7];
        window_ch.sample_ahead4 <= w.taps[8];
        window_ch.left_room <= w.left_room;
        window_ch.right_room <= w.right_room;
        @(posedge clk);
        while (!window_ch.ready)
            @(posedge clk);
        pending_derivatives.push_back(predict_derivative(w));
        @(negedge clk);
    endtask

    // Stops offering windows and waits until every predicted derivative has come back.
    task automatic drain_results();
        window_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending_derivatives.size() != 0)
            @(negedge clk);
    endtask

    // Writes both reciprocal registers; only called while the pipeline is empty.
    task automatic set_reciprocals(input logic [31:0] h_value, input logic [31:0] h_sq_value);
        cfg_write <= 1'b1;
        cfg_index <= REG_INV_H;
        cfg_data <= h_value;
        @(negedge clk);
        cfg_index <= REG_INV_H_SQ;
        cfg_data <= h_sq_value;
        @(negedge clk);
        cfg_write <= 1'b0;
        recip_h = h_value;
        recip_h_sq = h_sq_value;
        configs_written++;
        @(negedge clk);
    endtask

    // Directed windows under the reset reciprocals (1.0): every stencil for the first
    // and second derivative, the room boundaries, the biased commands, windows with no stencil,
    // the fourth neighbour read by the almost one-sided second derivative, and
    // full-scale samples that clip in both directions.
    task automatic test_directed_stencils();
        window_t w;
        w = '{cmd: CMD_FIRST, taps: poly_taps(ONE, 0), left_room: 4'd2, right_room: 4'd2};
        send_window(w);
        w = '{cmd: CMD_SECOND, taps: poly_taps(0, ONE), left_room: 4'd15, right_room: 4'd15};
        send_window(w);
        w = '{cmd: CMD_FIRST, taps: poly_taps(ONE, ONE), left_room: 4'd0, right_room: 4'd4};
        send_window(w);
        w.left_room = 4'd4;
        w.right_room = 4'd0;
        send_window(w);
        w.left_room = 4'd1;
        w.right_room = 4'd3;
        send_window(w);
        w.left_room = 4'd3;
        w.right_room = 4'd1;
        send_window(w);
        // Too little room on both sides, and one side empty with only three on the other.
        w.left_room = 4'd1;
        w.right_room = 4'd1;
        send_window(w);
        w.left_room = 4'd0;
        w.right_room = 4'd3;
        send_window(w);
        w = '{cmd: CMD_SECOND, taps: poly_taps(ONE, 3 * ONE), left_room: 4'd0, right_room: 4'd15};
        send_window(w);
        w.left_room = 4'd15;
        w.right_room = 4'd0;
        send_window(w);
        // Room three on one side, yet the fourth neighbour still enters the sum.
        w.left_room = 4'd1;
        w.right_room = 4'd3;
        w.taps[8] = w.taps[8] + 32'h0005_0000;
        send_window(w);
        w.left_room = 4'd3;
        w.right_room = 4'd1;
        w.taps[0] = w.taps[0] - 32'h0007_0000;
        send_window(w);
        w.left_room = 4'd0;
        w.right_room = 4'd0;
        send_window(w);
        w = '{cmd: CMD_FIRST_FWD, taps: poly_taps(2 * ONE, ONE), left_room: 4'd4, right_room: 4'd4};
        send_window(w);
        w.left_room = 4'd3;
        w.right_room = 4'd3;
        send_window(w);
        w.cmd = CMD_FIRST_BWD;
        w.left_room = 4'd15;
        w.right_room = 4'd15;
        send_window(w);
        w.left_room = 4'd0;
        w.right_room = 4'd5;
        send_window(w);
        // Alternating full-scale samples drive the second-derivative sums far outside the range.
        for (int i = 0; i < 9; i++)
            w.taps[i] = (i % 2 == 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
        w.cmd = CMD_FIRST;
        w.left_room = 4'd2;
        w.right_room = 4'd2;
        send_window(w);
        w.cmd = CMD_SECOND;
        send_window(w);
        for (int i = 0; i < 9; i++)
            w.taps[i] = (i % 2 == 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        send_window(w);
        // A flat window at the most negative sample cancels to zero.
        for (int i = 0; i < 9; i++)
            w.taps[i] = 32'h8000_0000;
        w.cmd = CMD_FIRST;
        send_window(w);
        drain_results();
    endtask

    // With a reciprocal of one half, a weighted sum of plus or minus one lands
    // exactly on a half and must round away from zero.
    task automatic test_rounding_ties();
        window_t w;
        set_reciprocals(32'h0000_8000, 32'h0000_8000);
        w = '{cmd: CMD_FIRST, taps: '0, left_room: 4'd2, right_room: 4'd2};
        w.taps[6] = 32'hFFFF_FFFF;
        send_window(w);
        w.taps[6] = 32'h0000_0001;
        send_window(w);
        drain_results();
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering,
    // so the pipeline fills and the window channel stalls.
    task automatic test_backpressure();
        set_reciprocals(32'($urandom_range(1, 32'h0004_0000)), 32'($urandom_range(1, 32'h0004_0000)));
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_left <= 200;
        repeat (60)
            send_window(random_window());
        drain_results();
    endtask

    // Random windows in eight segments: four traffic phases, each under two register
    // settings, the extremes among them. Every segment starts from an empty pipeline.
    task automatic test_random_phases();
        for (int seg = 0; seg < 8; seg++)
        begin
            case (seg)
                0: set_reciprocals(INV_RESET, INV_RESET);
                1: set_reciprocals(32'hFFFF_FFFF, 32'h0000_0000);
                2: set_reciprocals(32'h0000_0000, 32'hFFFF_FFFF);
                7: set_reciprocals($urandom, $urandom);
                default: set_reciprocals(32'($urandom_range(1, 32'h0004_0000)),
                                         32'($urandom_range(1, 32'h0004_0000)));
            endcase
            send_idle_pct = SEND_IDLE[seg / 2];
            recv_stall_pct = RECV_STALL[seg / 2];
            repeat (SEGMENT_ITEMS)
                send_window(random_window());
            drain_results();
        end
    endtask

    // Result ready: a pending hold-off wins, otherwise it stalls at the phase's rate.
    always @(negedge clk)
    begin
        if (hold_off_left != 0)
        begin
            result_ch.ready <= 1'b0;
            hold_off_left <= hold_off_left - 1;
        end
        else
        begin
            result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Every accepted result is matched against the oldest predicted derivative.
    always @(posedge clk)
    begin : result_check
        derivative_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_derivatives.size() == 0)
            begin
                $error("result transaction with no window waiting for it");
                error_count++;
            end
            else
            begin
                want = pending_derivatives.pop_front();
                results_checked++;
                stencil_hits[int'(want.stencil)]++;
                if (want.saturated)
                    saturations_seen++;
                if (result_ch.derivative !== want.derivative)
                begin
                    $error("derivative mismatch: expected %0d, got %0d",
                           want.derivative, result_ch.derivative);
                    error_count++;
                end
                if (result_ch.stencil_used !== want.stencil)
                begin
                    $error("stencil_used mismatch: expected %0d, got %0d",
                           want.stencil, result_ch.stencil_used);
                    error_count++;
                end
                if (result_ch.saturated !== want.saturated)
                begin
                    $error("saturated mismatch: expected %0d, got %0d",
                           want.saturated, result_ch.saturated);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = REG_INV_H;
        cfg_data = '0;
        window_ch.valid = 1'b0;
        window_ch.cmd = CMD_FIRST;
        window_ch.sample_back4 = '0;
        window_ch.sample_back3 = '0;
        window_ch.sample_back2 = '0;
        window_ch.sample_back1 = '0;
        window_ch.sample_center = '0;
        window_ch.sample_ahead1 = '0;
        window_ch.sample_ahead2 = '0;
        window_ch.sample_ahead3 = '0;
        window_ch.sample_ahead4 = '0;
        window_ch.left_room = '0;
        window_ch.right_room = '0;
        result_ch.ready = 1'b0;
        recip_h = INV_RESET;
        recip_h_sq = INV_RESET;
        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_stencils();
        test_rounding_ties();
        test_backpressure();
        test_random_phases();

        // Nothing is pending now; the final wait catches any stray result.
        repeat (20)
            @(posedge clk);

        $display("Checked %0d derivatives under %0d register settings, %0d of them clipped.",
                 results_checked, configs_written, saturations_seen);
        $display("Per stencil: central %0d, right %0d, left %0d, almost right %0d, %s %0d, none %0d.",
                 stencil_hits[0], stencil_hits[1], stencil_hits[2], stencil_hits[3],
                 "almost left", stencil_hits[4], stencil_hits[5]);
        if (error_count == 0)
            $display("boundary_aware_stencil_derivative verification clean");
        else
            $display("boundary_aware_stencil_derivative verification failed");
        $finish;
    end

endmodule
